>>> sv/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define TTCC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ttcc assertion failed");

// next-cycle implication, disabled in reset
`define TTCC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ttcc assertion failed");

`else

`define TTCC_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TTCC_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> sv/ttcc_pkg.sv
// types and constants of the text terminal cursor control unit
package ttcc_pkg;

    localparam int COL_W   = 5;
    localparam int ROW_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int TAB_W   = 4;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    localparam logic [TAB_W-1:0] TAB_RESET = 4'd4;
    localparam logic [TAB_W-1:0] TAB_MAX   = 4'd8;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DRAW   = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_DONE   = 2'd3
    } kind_t;

    // classified operation for the back end
    typedef enum logic [2:0] {
        OP_DRAW,
        OP_BS,
        OP_TAB,
        OP_LF,
        OP_VT,
        OP_FF,
        OP_CR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] glyph;
    } op_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_EXEC,
        ST_DIV,
        ST_STEP,
        ST_DONE
    } back_state_t;

endpackage

>>> sv/ttcc_front.sv
// front end: takes character items and classifies them into operations
module ttcc_front (
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ttcc_pkg::CHAR_W-1:0] char_code,
    input  ttcc_pkg::q_status_t         q_status,
    output logic                        push,
    output ttcc_pkg::op_item_t          push_item
);

    // accept while the queue has room
    assign in_ready = !q_status.full;
    assign push     = in_valid && !q_status.full;

    // decode control codes
    always_comb
    begin
        push_item.glyph = char_code;
        case (char_code)
            ttcc_pkg::CH_BS:  push_item.op = ttcc_pkg::OP_BS;
            ttcc_pkg::CH_TAB: push_item.op = ttcc_pkg::OP_TAB;
            ttcc_pkg::CH_LF:  push_item.op = ttcc_pkg::OP_LF;
            ttcc_pkg::CH_VT:  push_item.op = ttcc_pkg::OP_VT;
            ttcc_pkg::CH_FF:  push_item.op = ttcc_pkg::OP_FF;
            ttcc_pkg::CH_CR:  push_item.op = ttcc_pkg::OP_CR;
            default:          push_item.op = ttcc_pkg::OP_DRAW;
        endcase
    end

endmodule

>>> sv/ttcc_queue.sv
// short operation queue between front and back end, registered read
module ttcc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ttcc_pkg::op_item_t  push_item,
    input  logic                pop,
    output ttcc_pkg::op_item_t  pop_item,
    output ttcc_pkg::q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ttcc_pkg::op_item_t mem [DEPTH];
    ttcc_pkg::op_item_t pop_item_reg;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_item     = pop_item_reg;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
        if (do_pop)
        begin
            pop_item_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

>>> sv/ttcc_back.sv
// back end: cursor state, operation sequencer, tab divider and output register
module ttcc_back #(
    parameter int SCREEN_COLS = 16,
    parameter int SCREEN_ROWS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [ttcc_pkg::TAB_W-1:0]  tab_width,
    input  ttcc_pkg::q_status_t         q_status,
    input  ttcc_pkg::op_item_t          q_item,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic [ttcc_pkg::CHAR_W-1:0] glyph,
    output logic [ttcc_pkg::ROW_W-1:0]  row,
    output logic [ttcc_pkg::COL_W-1:0]  col,
    output logic                        last
);

    localparam logic [ttcc_pkg::COL_W-1:0] COLS_C   = ttcc_pkg::COL_W'(SCREEN_COLS);
    localparam logic [ttcc_pkg::COL_W-1:0] LAST_COL = ttcc_pkg::COL_W'(SCREEN_COLS - 1);
    localparam logic [ttcc_pkg::ROW_W-1:0] LAST_ROW = ttcc_pkg::ROW_W'(SCREEN_ROWS - 1);
    localparam logic [2:0] MSB_IDX = 3'(ttcc_pkg::COL_W - 1);

    ttcc_pkg::back_state_t        state_reg, state_next;
    logic [ttcc_pkg::TAB_W-1:0]   tab_reg;
    logic [ttcc_pkg::TAB_W-1:0]   tw_eff;
    logic [ttcc_pkg::COL_W-1:0]   col_reg, col_next;
    logic [ttcc_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [2:0]                   rem_reg, rem_next;
    logic [2:0]                   bit_idx_reg, bit_idx_next;
    logic [3:0]                   rem_shift;
    logic                         can_emit;

    logic                         out_valid_reg, out_valid_next;
    ttcc_pkg::kind_t              out_kind_reg, out_kind_next;
    logic [ttcc_pkg::CHAR_W-1:0]  out_glyph_reg, out_glyph_next;
    logic [ttcc_pkg::ROW_W-1:0]   out_row_reg, out_row_next;
    logic [ttcc_pkg::COL_W-1:0]   out_col_reg, out_col_next;
    logic                         out_last_reg, out_last_next;

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign glyph     = out_glyph_reg;
    assign row       = out_row_reg;
    assign col       = out_col_reg;
    assign last      = out_last_reg;

    // tab width clamped to 1..8
    always_comb
    begin
        if (tab_reg == '0)
        begin
            tw_eff = 4'd1;
        end
        else if (tab_reg > ttcc_pkg::TAB_MAX)
        begin
            tw_eff = ttcc_pkg::TAB_MAX;
        end
        else
        begin
            tw_eff = tab_reg;
        end
    end

    // one remainder bit per cycle of the tab divider
    assign rem_shift = {rem_reg, col_reg[bit_idx_reg]};
    assign can_emit  = !out_valid_reg || out_ready;

    // sequencer: next state, cursor and output register
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        rem_next       = rem_reg;
        bit_idx_next   = bit_idx_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_glyph_next = out_glyph_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ttcc_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    state_next = ttcc_pkg::ST_WRAP;
                end
            end

            // pending wrap from a column past the last one
            ttcc_pkg::ST_WRAP:
            begin
                if (col_reg >= COLS_C)
                begin
                    if (row_reg >= LAST_ROW)
                    begin
                        if (can_emit)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = ttcc_pkg::KIND_SCROLL;
                            out_glyph_next = '0;
                            out_row_next   = '0;
                            out_col_next   = '0;
                            out_last_next  = 1'b0;
                            col_next       = '0;
                            state_next     = ttcc_pkg::ST_EXEC;
                        end
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        col_next   = '0;
                        state_next = ttcc_pkg::ST_EXEC;
                    end
                end
                else
                begin
                    state_next = ttcc_pkg::ST_EXEC;
                end
            end

            ttcc_pkg::ST_EXEC:
            begin
                case (q_item.op)
                    ttcc_pkg::OP_BS:
                    begin
                        if (col_reg == '0)
                        begin
                            if (row_reg != '0)
                            begin
                                row_next = row_reg - 1'b1;
                                col_next = LAST_COL;
                            end
                        end
                        else
                        begin
                            col_next = col_reg - 1'b1;
                        end
                        state_next = ttcc_pkg::ST_DONE;
                    end
                    ttcc_pkg::OP_TAB:
                    begin
                        rem_next     = '0;
                        bit_idx_next = MSB_IDX;
                        state_next   = ttcc_pkg::ST_DIV;
                    end
                    ttcc_pkg::OP_LF:
                    begin
                        col_next   = '0;
                        state_next = ttcc_pkg::ST_DONE;
                    end
                    ttcc_pkg::OP_VT, ttcc_pkg::OP_CR:
                    begin
                        if (row_reg >= LAST_ROW)
                        begin
                            if (can_emit)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = ttcc_pkg::KIND_SCROLL;
                                out_glyph_next = '0;
                                out_row_next   = '0;
                                out_col_next   = '0;
                                out_last_next  = 1'b0;
                                if (q_item.op == ttcc_pkg::OP_CR)
                                begin
                                    col_next = '0;
                                end
                                state_next = ttcc_pkg::ST_DONE;
                            end
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                            if (q_item.op == ttcc_pkg::OP_CR)
                            begin
                                col_next = '0;
                            end
                            state_next = ttcc_pkg::ST_DONE;
                        end
                    end
                    ttcc_pkg::OP_FF:
                    begin
                        if (can_emit)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = ttcc_pkg::KIND_CLEAR;
                            out_glyph_next = '0;
                            out_row_next   = '0;
                            out_col_next   = '0;
                            out_last_next  = 1'b0;
                            col_next       = '0;
                            row_next       = '0;
                            state_next     = ttcc_pkg::ST_DONE;
                        end
                    end
                    default:
                    begin
                        // printable item: draw and advance
                        if (can_emit)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = ttcc_pkg::KIND_DRAW;
                            out_glyph_next = q_item.glyph;
                            out_row_next   = row_reg;
                            out_col_next   = col_reg;
                            out_last_next  = 1'b0;
                            col_next       = col_reg + 1'b1;
                            state_next     = ttcc_pkg::ST_DONE;
                        end
                    end
                endcase
            end

            // restoring remainder of column by tab width
            ttcc_pkg::ST_DIV:
            begin
                if (rem_shift >= tw_eff)
                begin
                    rem_next = 3'(rem_shift - tw_eff);
                end
                else
                begin
                    rem_next = rem_shift[2:0];
                end
                if (bit_idx_reg == '0)
                begin
                    state_next = ttcc_pkg::ST_STEP;
                end
                else
                begin
                    bit_idx_next = bit_idx_reg - 1'b1;
                end
            end

            // next tab stop
            ttcc_pkg::ST_STEP:
            begin
                col_next   = ttcc_pkg::COL_W'({1'b0, col_reg} + {2'b00, tw_eff}
                                              - {3'b000, rem_reg});
                state_next = ttcc_pkg::ST_DONE;
            end

            ttcc_pkg::ST_DONE:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = ttcc_pkg::KIND_DONE;
                    out_glyph_next = '0;
                    out_row_next   = row_reg;
                    out_col_next   = col_reg;
                    out_last_next  = 1'b1;
                    state_next     = ttcc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ttcc_pkg::ST_IDLE;
            end
        endcase
    end

    // control and cursor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttcc_pkg::ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            tab_reg       <= ttcc_pkg::TAB_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                tab_reg <= tab_width;
            end
        end
    end

    // divider and result payload
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        bit_idx_reg   <= bit_idx_next;
        out_kind_reg  <= out_kind_next;
        out_glyph_reg <= out_glyph_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_last_reg  <= out_last_next;
    end

endmodule

>>> sv/text_terminal_cursor_control_unit.sv
// top level of the text terminal cursor control unit
//
// Character items enter on in_valid/in_ready with char_code. Each item
// gives one to three result items on out_valid/out_ready: an optional
// scroll for a pending wrap, an optional draw, scroll or clear command,
// and always a done item (kind done, last high) carrying the cursor.
// tab_width is written on cfg_valid/cfg_ready (always ready); the user
// is to write it only while idle, the block itself does not enforce it.
// The front end decodes items into a short queue; the back end sequencer
// handles one operation at a time. A plain character passes the back end
// states fetch, wrap, execute and done; a tab also passes the divide and
// step states, as its remainder by the tab width is found one column bit
// per cycle. Reset homes the cursor to row 0, column 0 and sets the tab
// width to 4. A stalled receiver holds the output register; the sequencer
// waits and the queue keeps taking items until it is full.
module text_terminal_cursor_control_unit #(
    parameter int SCREEN_COLS = 16,
    parameter int SCREEN_ROWS = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ttcc_pkg::CHAR_W-1:0] char_code,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ttcc_pkg::TAB_W-1:0]  tab_width,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic [ttcc_pkg::CHAR_W-1:0] glyph,
    output logic [ttcc_pkg::ROW_W-1:0]  row,
    output logic [ttcc_pkg::COL_W-1:0]  col,
    output logic                        last
);

    ttcc_pkg::q_status_t q_status;
    ttcc_pkg::op_item_t  push_item;
    ttcc_pkg::op_item_t  pop_item;
    logic                push;
    logic                pop;

    assign cfg_ready = 1'b1;

    // decode
    ttcc_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    // operation queue
    ttcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    // execution
    ttcc_back #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .tab_width (tab_width),
        .q_status  (q_status),
        .q_item    (pop_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .glyph     (glyph),
        .row       (row),
        .col       (col),
        .last      (last)
    );

    // checks
    `include "assert_macros.svh"

    `TTCC_ASSERT_IMP(a_last_is_done, clk, rst_n, out_valid && last, kind == ttcc_pkg::KIND_DONE)
    `TTCC_ASSERT_IMP(a_row_on_screen, clk, rst_n, out_valid, row <= 3'(SCREEN_ROWS - 1))
    `TTCC_ASSERT_IMP(a_cmd_zero, clk, rst_n, out_valid && (kind == ttcc_pkg::KIND_SCROLL || kind == ttcc_pkg::KIND_CLEAR), row == '0 && col == '0 && glyph == '0 && !last)
    `TTCC_ASSERT_NXT(a_push_queued, clk, rst_n, in_valid && in_ready, !q_status.empty)

endmodule

>>> bench/tb_text_terminal_cursor_control_unit.sv
// testbench for the text terminal cursor control unit: directed table, random phases, scoreboard
module tb_text_terminal_cursor_control_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_COLS = 16;
    localparam int SCREEN_ROWS = 8;
    localparam int CLK_HALF    = 6;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_REPORTS = 40;

    // one display command as seen on the output channel
    typedef struct {
        ttcc_pkg::kind_t                kind;
        logic [ttcc_pkg::CHAR_W-1:0]    glyph;
        logic [ttcc_pkg::ROW_W-1:0]     row;
        logic [ttcc_pkg::COL_W-1:0]     col;
        logic                           last;
    } lcd_cmd_t;

    // directed stimulus row, cursor typed in where it is obvious
    typedef struct {
        logic [ttcc_pkg::CHAR_W-1:0]    code;
        bit                             typed;
        logic [ttcc_pkg::ROW_W-1:0]     row;
        logic [ttcc_pkg::COL_W-1:0]     col;
    } char_row_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic [ttcc_pkg::CHAR_W-1:0]    char_code = '0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ttcc_pkg::TAB_W-1:0]     tab_width = ttcc_pkg::TAB_RESET;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [1:0]                     kind;
    logic [ttcc_pkg::CHAR_W-1:0]    glyph;
    logic [ttcc_pkg::ROW_W-1:0]     row;
    logic [ttcc_pkg::COL_W-1:0]     col;
    logic                           last;

    // predictor state
    logic [ttcc_pkg::COL_W-1:0]     pred_col    = '0;
    logic [ttcc_pkg::ROW_W-1:0]     pred_row    = '0;
    logic [ttcc_pkg::TAB_W-1:0]     tab_setting = ttcc_pkg::TAB_RESET;
    lcd_cmd_t                       expected_cmds[$];

    int error_count   = 0;
    int chars_sent    = 0;
    int cmds_checked  = 0;
    int tab_writes    = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    bit hold_request  = 1'b0;

    // directed part: extremes, every control code, backspace corners, wraps and scrolls
    char_row_t char_table [26] = '{
        '{8'h00,            1'b1, 3'd0, 5'd1},
        '{8'hFF,            1'b1, 3'd0, 5'd2},
        '{ttcc_pkg::CH_TAB, 1'b1, 3'd0, 5'd4},
        '{ttcc_pkg::CH_BS,  1'b1, 3'd0, 5'd3},
        '{ttcc_pkg::CH_LF,  1'b1, 3'd0, 5'd0},
        '{ttcc_pkg::CH_BS,  1'b1, 3'd0, 5'd0},
        '{ttcc_pkg::CH_CR,  1'b1, 3'd1, 5'd0},
        '{ttcc_pkg::CH_BS,  1'b1, 3'd0, 5'd15},
        '{8'h78,            1'b1, 3'd0, 5'd16},
        '{8'h79,            1'b1, 3'd1, 5'd1},
        '{ttcc_pkg::CH_VT,  1'b1, 3'd2, 5'd1},
        '{ttcc_pkg::CH_CR,  1'b0, 3'd0, 5'd0},
        '{ttcc_pkg::CH_CR,  1'b0, 3'd0, 5'd0},
        '{ttcc_pkg::CH_CR,  1'b0, 3'd0, 5'd0},
        '{ttcc_pkg::CH_CR,  1'b0, 3'd0, 5'd0},
        '{ttcc_pkg::CH_CR,  1'b0, 3'd0, 5'd0},
        '{ttcc_pkg::CH_VT,  1'b0, 3'd0, 5'd0},
        '{ttcc_pkg::CH_BS,  1'b0, 3'd0, 5'd0},
        '{ttcc_pkg::CH_TAB, 1'b0, 3'd0, 5'd0},
        '{8'h41,            1'b0, 3'd0, 5'd0},
        '{ttcc_pkg::CH_TAB, 1'b0, 3'd0, 5'd0},
        '{ttcc_pkg::CH_TAB, 1'b0, 3'd0, 5'd0},
        '{ttcc_pkg::CH_TAB, 1'b0, 3'd0, 5'd0},
        '{ttcc_pkg::CH_TAB, 1'b0, 3'd0, 5'd0},
        '{ttcc_pkg::CH_CR,  1'b0, 3'd0, 5'd0},
        '{ttcc_pkg::CH_FF,  1'b1, 3'd0, 5'd0}
    };

    text_terminal_cursor_control_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .tab_width (tab_width),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .glyph     (glyph),
        .row       (row),
        .col       (col),
        .last      (last)
    );

    // clock
    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("text_terminal_cursor_control_unit test failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic void push_cmd(input ttcc_pkg::kind_t k,
                                     input logic [ttcc_pkg::CHAR_W-1:0] g,
                                     input logic [ttcc_pkg::ROW_W-1:0] r,
                                     input logic [ttcc_pkg::COL_W-1:0] c,
                                     input logic l);
        lcd_cmd_t cmd;
        cmd.kind  = k;
        cmd.glyph = g;
        cmd.row   = r;
        cmd.col   = c;
        cmd.last  = l;
        expected_cmds.push_back(cmd);
    endfunction

    // move down one row, scrolling on the bottom row
    function automatic void line_down();
        if (int'(pred_row) >= SCREEN_ROWS - 1)
            push_cmd(ttcc_pkg::KIND_SCROLL, '0, '0, '0, 1'b0);
        else
            pred_row = pred_row + 1'b1;
    endfunction

    // cursor predictor: queues the commands one character causes
    function automatic void advance_cursor(input logic [ttcc_pkg::CHAR_W-1:0] code);
        int tw;
        tw = int'(tab_setting);
        if (tw == 0)
            tw = 1;
        if (tw > int'(ttcc_pkg::TAB_MAX))
            tw = int'(ttcc_pkg::TAB_MAX);
        // pending wrap from a previous character
        if (int'(pred_col) >= SCREEN_COLS)
        begin
            line_down();
            pred_col = '0;
        end
        case (code)
            ttcc_pkg::CH_BS:
            begin
                if (pred_col == 0)
                begin
                    if (pred_row > 0)
                    begin
                        pred_row = pred_row - 1'b1;
                        pred_col = ttcc_pkg::COL_W'(SCREEN_COLS - 1);
                    end
                end
                else
                    pred_col = pred_col - 1'b1;
            end
            ttcc_pkg::CH_TAB:
                pred_col = ttcc_pkg::COL_W'(int'(pred_col) + tw - (int'(pred_col) % tw));
            ttcc_pkg::CH_LF:  pred_col = '0;
            ttcc_pkg::CH_VT:  line_down();
            ttcc_pkg::CH_FF:
            begin
                push_cmd(ttcc_pkg::KIND_CLEAR, '0, '0, '0, 1'b0);
                pred_col = '0;
                pred_row = '0;
            end
            ttcc_pkg::CH_CR:
            begin
                line_down();
                pred_col = '0;
            end
            default:
            begin
                push_cmd(ttcc_pkg::KIND_DRAW, code, pred_row, pred_col, 1'b0);
                pred_col = pred_col + 1'b1;
            end
        endcase
        push_cmd(ttcc_pkg::KIND_DONE, '0, pred_row, pred_col, 1'b1);
    endfunction

    // output side: check accepted items, drive ready with stalls and hold-offs
    always @(posedge clk)
    begin
        lcd_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            cmds_checked++;
            if (expected_cmds.size() == 0)
                report_mismatch("unexpected item, kind", int'(kind), -1);
            else
            begin
                want = expected_cmds.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", int'(kind), int'(want.kind));
                if (glyph !== want.glyph)
                    report_mismatch("glyph", int'(glyph), int'(want.glyph));
                if (row !== want.row)
                    report_mismatch("row", int'(row), int'(want.row));
                if (col !== want.col)
                    report_mismatch("col", int'(col), int'(want.col));
                if (last !== want.last)
                    report_mismatch("last", int'(last), int'(want.last));
            end
        end
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // offer one character and wait until it is taken
    task automatic send_char(input logic [ttcc_pkg::CHAR_W-1:0] code);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid  <= 1'b1;
        char_code <= code;
        do
            @(posedge clk);
        while (!in_ready);
        advance_cursor(code);
        chars_sent++;
    endtask

    // stop offering and wait for every outstanding command
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_tab_width(input logic [ttcc_pkg::TAB_W-1:0] value);
        cfg_valid <= 1'b1;
        tab_width <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tab_setting = value;
        tab_writes++;
    endtask

    // random phase, mostly drawing with a good share of control codes
    task automatic random_phase(input int count, input int idle, input int stall,
                                input bit pressure);
        int pick;
        logic [ttcc_pkg::CHAR_W-1:0] code;
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            if (pressure && i == 20)
                hold_request = 1'b1;
            if (pressure && i == 70)
                drain_results();
            pick = $urandom_range(99);
            if (pick < 36)
            begin
                case ($urandom_range(4))
                    0:       code = ttcc_pkg::CH_BS;
                    1:       code = ttcc_pkg::CH_TAB;
                    2:       code = ttcc_pkg::CH_LF;
                    3:       code = ttcc_pkg::CH_VT;
                    default: code = ttcc_pkg::CH_CR;
                endcase
            end
            else if (pick < 39)
                code = ttcc_pkg::CH_FF;
            else
                code = ttcc_pkg::CHAR_W'($urandom_range(255));
            send_char(code);
        end
        drain_results();
    endtask

    // main sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset tab width
        foreach (char_table[i])
        begin
            send_char(char_table[i].code);
            if (char_table[i].typed)
            begin
                expected_cmds[$].row = char_table[i].row;
                expected_cmds[$].col = char_table[i].col;
            end
        end
        drain_results();

        write_tab_width(4'd1);
        random_phase(110, 0, 0, 1'b0);
        write_tab_width(ttcc_pkg::TAB_MAX);
        random_phase(110, 75, 0, 1'b0);
        write_tab_width(4'd0);
        random_phase(110, 0, 75, 1'b0);
        write_tab_width(4'd15);
        random_phase(110, 24, 24, 1'b1);
        write_tab_width(ttcc_pkg::TAB_W'($urandom_range(15)));
        random_phase(50, 0, 0, 1'b0);

        // let any stray item show up before the verdict
        stall_pct = 0;
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d characters over %0d tab width settings, checked %0d commands",
                 chars_sent, tab_writes + 1, cmds_checked);
        $display("phases: back to back, sender idling, receiver stalling, both, long hold-off");
        if (error_count == 0 && expected_cmds.size() == 0)
            $display("text_terminal_cursor_control_unit test passed");
        else
        begin
            if (expected_cmds.size() != 0)
                $display("%0d commands never arrived", expected_cmds.size());
            $display("text_terminal_cursor_control_unit test failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/ttcc_pkg.sv
sv/ttcc_front.sv
sv/ttcc_queue.sv
sv/ttcc_back.sv
sv/text_terminal_cursor_control_unit.sv
bench/tb_text_terminal_cursor_control_unit.sv
